// ===== hdl/snmp_request_ber_parser_top_defines.svh =====
// assertion macros for the snmp request ber parser
// used by snmp_request_ber_parser_top only
`ifndef SNMP_REQUEST_BER_PARSER_TOP_DEFINES_SVH
`define SNMP_REQUEST_BER_PARSER_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define SRBP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define SRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/snmp_pkg.sv =====
// shared types and constants for the snmp request ber parser
// no dependencies
package snmp_pkg;

  localparam int unsigned MaxSubids     = 20;
  localparam int unsigned MaxVarbinds   = 20;
  localparam int unsigned CommunitySize = 32;

  typedef enum logic [3:0] {
    KIND_VERSION = 4'd0, KIND_COMM = 4'd1, KIND_PDU = 4'd2, KIND_REQID = 4'd3,
    KIND_NONREP = 4'd4, KIND_MAXREP = 4'd5, KIND_SUBID = 4'd6,
    KIND_ACCEPT = 4'd7, KIND_REJECT = 4'd8
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE = 4'd0, ERR_TAG = 4'd1, ERR_TRUNC = 4'd2, ERR_LONGLEN = 4'd3,
    ERR_HEADER = 4'd4, ERR_VERSION = 4'd5, ERR_COMM = 4'd6, ERR_PDULEN = 4'd7,
    ERR_INT = 4'd8, ERR_VBLIST = 4'd9, ERR_VBMANY = 4'd10, ERR_VARBIND = 4'd11,
    ERR_OID = 4'd12, ERR_SUBMANY = 4'd13, ERR_VALUE = 4'd14
  } err_e;

  // one decoded result
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [4:0]  vb;
    logic [4:0]  sid;
    logic [3:0]  code;
  } res_t;

  // results caused by one byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t [2:0] r;
  } res_grp_t;

  function automatic logic tag_ok(input logic [7:0] t);
    case (t) inside
      8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h30, 8'h41, 8'h42, 8'h43,
      8'h80, 8'h81, 8'h82, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA5, 8'hA6,
      8'hA7: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

// ===== hdl/snmp_out_queue.sv =====
// result queue: takes up to three results per byte, delivers one per cycle while ready_i is high
// depends on snmp_pkg
module snmp_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  snmp_pkg::res_grp_t  grp_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                ready_i,
  output snmp_pkg::res_t      res_o,
  output logic                last_o
);
  import snmp_pkg::*;

  // slots hold results plus run_end flag
  localparam int unsigned Depth = 8;
  res_t       mem_q [Depth];
  logic       lst_q [Depth];
  logic [2:0] wp_q, rp_q;
  logic [3:0] cnt_q;
  logic       pop;
  logic [1:0] n;

  assign n       = push_i ? grp_i.cnt : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != 4'd0;
  assign res_o   = mem_q[rp_q];
  assign last_o  = lst_q[rp_q];
  assign space_o = cnt_q <= 4'd5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + {1'b0, n};
      rp_q  <= rp_q + {2'b0, pop};
      cnt_q <= cnt_q + {2'b0, n} - {3'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n) begin
        mem_q[wp_q + 3'(i)] <= grp_i.r[i];
        lst_q[wp_q + 3'(i)] <= (2'(i) == n - 2'd1);
      end
    end
  end
endmodule

// ===== hdl/snmp_request_ber_parser_top.sv =====
// snmp v1/v2c request ber decoder, top level
// depends on snmp_pkg, snmp_out_queue and the defines header
//
// channel | dir | handshake                  | payload
// in      | in  | in_valid_i / in_ready_o    | data_byte_i, last_byte_i
// out     | out | out_valid_o / out_ready_i  | kind_o value_o varbind_number_o
//         |     |                            | subid_number_o error_code_o run_end_o
//
// one request byte per cycle while in_ready_o is high; the byte is parsed in the
// cycle it is taken and its zero to three results land in an eight-slot queue
// results leave the queue one per cycle while out_ready_i is high, so three-result bytes briefly slow input
// in_ready_o drops only when the queue lacks room for three more results
// reset restores the parser to expect an outer sequence tag; same after last byte
`include "snmp_request_ber_parser_top_defines.svh"
module snmp_request_ber_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  kind_o,
  output logic [31:0] value_o,
  output logic [4:0]  varbind_number_o,
  output logic [4:0]  subid_number_o,
  output logic [3:0]  error_code_o,
  output logic        run_end_o
);
  import snmp_pkg::*;

  // phases of the message walk
  localparam logic [3:0] PH_OUTER = 4'd0, PH_VERSION = 4'd1, PH_COMM = 4'd2,
    PH_PDU = 4'd3, PH_REQID = 4'd4, PH_NONREP = 4'd5, PH_MAXREP = 4'd6,
    PH_VBLIST = 4'd7, PH_VARBIND = 4'd8, PH_OID = 4'd9, PH_VALUE = 4'd10;
  // stage within one tlv header
  localparam logic [1:0] ST_TAG = 2'd0, ST_LEN = 2'd1, ST_LENX = 2'd2, ST_BODY = 2'd3;

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  stage_q, stage_d;
  logic [15:0] pos_q, pos_d, mend_q, mend_d, rem_q, rem_d;
  logic [7:0]  tag_q, tag_d;
  logic [1:0]  lbl_q, lbl_d;
  logic [31:0] acc_q, acc_d;
  logic [4:0]  sidc_q, sidc_d, vbc_q, vbc_d;
  logic        err_q, err_d, sopen_q, sopen_d, known_q, known_d, first_q, first_d;
  logic        sid_full_q, sid_full_d; // subid count reached 32 (5-bit field wraps)

  res_grp_t grp;
  logic     take, space;

  assign in_ready_o = space;
  assign take       = in_valid_i && in_ready_o;

  function automatic res_t mk(input kind_e k, input logic [31:0] v,
                              input logic [4:0] vb, input logic [4:0] sid,
                              input err_e c);
    res_t r;
    r.kind = k; r.value = v; r.vb = vb; r.sid = sid; r.code = c;
    return r;
  endfunction

  // per-byte parse, a direct walk of the ber structure
  always_comb begin
    logic [16:0] eend;
    logic [6:0]  k;
    logic        fail, hd;
    logic [15:0] len;
    logic [7:0]  b;
    logic [5:0]  sidx;
    logic [1:0]  q40;
    logic [7:0]  r40;
    err_e        ec;
    b = data_byte_i;
    phase_d = phase_q; stage_d = stage_q; pos_d = pos_q; mend_d = mend_q;
    rem_d = rem_q; tag_d = tag_q; lbl_d = lbl_q; acc_d = acc_q; sidc_d = sidc_q;
    vbc_d = vbc_q; err_d = err_q; sopen_d = sopen_q; known_d = known_q;
    first_d = first_q; sid_full_d = sid_full_q;
    grp = '0; fail = 1'b0; ec = ERR_NONE; hd = 1'b0; len = '0; k = '0;
    eend = '0;
    sidx = {sid_full_q, sidc_q};
    // first oid byte split by 40, by compare and subtract
    q40 = 2'd0; r40 = b;
    if (b >= 8'd120) begin
      q40 = 2'd3; r40 = b - 8'd120;
    end else if (b >= 8'd80) begin
      q40 = 2'd2; r40 = b - 8'd80;
    end else if (b >= 8'd40) begin
      q40 = 2'd1; r40 = b - 8'd40;
    end

    if (err_q) begin
      // drop bytes until the message ends
    end else if (known_q && pos_q >= mend_q) begin
      fail = 1'b1; ec = ERR_HEADER;
    end else begin
      case (stage_q)
        ST_TAG: begin
          if (phase_q == PH_VARBIND && 32'(vbc_q) >= MaxVarbinds) begin
            fail = 1'b1; ec = ERR_VBMANY;
          end else if (!tag_ok(b)) begin
            fail = 1'b1; ec = ERR_TAG;
          end else begin
            tag_d = b; stage_d = ST_LEN;
          end
        end
        ST_LEN: begin
          k = b[6:0];
          if (b[7]) begin
            if (k > 7'd2) begin
              fail = 1'b1; ec = ERR_LONGLEN;
            end else if (k == 7'd0) begin
              hd = 1'b1; len = '0;
            end else begin
              rem_d = '0; lbl_d = k[1:0]; stage_d = ST_LENX;
            end
          end else begin
            hd = 1'b1; len = {8'd0, b};
          end
        end
        ST_LENX: begin
          len = {rem_q[7:0], b}; rem_d = len; lbl_d = lbl_q - 2'd1;
          hd = (lbl_q == 2'd1);
        end
        default: begin
          rem_d = rem_q - 16'd1;
          case (phase_q)
            PH_VERSION: begin
              if (b > 8'd1) begin
                fail = 1'b1; ec = ERR_VERSION;
              end else begin
                grp.cnt = 2'd1; grp.r[0] = mk(KIND_VERSION, {24'd0, b}, '0, '0, ERR_NONE);
                phase_d = PH_COMM; stage_d = ST_TAG;
              end
            end
            PH_COMM: begin
              grp.cnt = 2'd1; grp.r[0] = mk(KIND_COMM, {24'd0, b}, '0, '0, ERR_NONE);
              if (rem_d == '0) begin phase_d = PH_PDU; stage_d = ST_TAG; end
            end
            PH_REQID, PH_NONREP, PH_MAXREP: begin
              logic [31:0] a;
              a = acc_q;
              if (first_q && phase_q == PH_REQID && b[7]) a = '1;
              first_d = 1'b0;
              acc_d = {a[23:0], b};
              if (rem_d == '0) begin
                grp.cnt = 2'd1;
                grp.r[0] = mk(kind_e'(4'd3 + (phase_q - PH_REQID)), acc_d, '0, '0,
                              ERR_NONE);
                phase_d = phase_q + 4'd1; stage_d = ST_TAG;
              end
            end
            PH_OID: begin
              if (sidx == 6'd0) begin
                if (b[7]) begin
                  fail = 1'b1; ec = ERR_OID;
                end else begin
                  grp.cnt = 2'd2;
                  grp.r[0] = mk(KIND_SUBID, {30'd0, q40}, vbc_q, 5'd0, ERR_NONE);
                  grp.r[1] = mk(KIND_SUBID, {24'd0, r40}, vbc_q, 5'd1, ERR_NONE);
                  sidc_d = 5'd2;
                end
              end else begin
                logic [31:0] a;
                a = acc_q;
                if (!sopen_q) begin
                  if (32'(sidx) >= MaxSubids) begin
                    fail = 1'b1; ec = ERR_SUBMANY;
                  end
                  a = '0; sopen_d = 1'b1;
                end
                if (!fail) begin
                  acc_d = {a[24:0], b[6:0]};
                  if (b[7]) begin
                    if (rem_d == '0) begin fail = 1'b1; ec = ERR_OID; end
                  end else begin
                    grp.cnt = 2'd1;
                    grp.r[0] = mk(KIND_SUBID, acc_d, vbc_q, sidc_q, ERR_NONE);
                    {sid_full_d, sidc_d} = sidx + 6'd1;
                    sopen_d = 1'b0;
                  end
                end
              end
              if (!fail && rem_d == '0) begin phase_d = PH_VALUE; stage_d = ST_TAG; end
            end
            default: begin
              if (rem_d == '0) begin
                vbc_d = vbc_q + 5'd1; phase_d = PH_VARBIND; stage_d = ST_TAG;
              end
            end
          endcase
        end
      endcase

      // header complete
      if (hd && !fail) begin
        rem_d = len;
        eend  = 17'(pos_q) + 17'd1 + 17'(len);
        case (phase_q)
          PH_OUTER: begin
            if (tag_q != 8'h30 || eend > 17'h0FFFF) begin fail = 1'b1; ec = ERR_HEADER; end
            else begin
              mend_d = eend[15:0]; known_d = 1'b1; phase_d = PH_VERSION; stage_d = ST_TAG;
            end
          end
          PH_VERSION: begin
            if (tag_q != 8'h02 || len != 16'd1) begin fail = 1'b1; ec = ERR_VERSION; end
            else if (eend > 17'(mend_q)) begin fail = 1'b1; ec = ERR_TRUNC; end
            else stage_d = ST_BODY;
          end
          PH_COMM: begin
            if (tag_q != 8'h04 || 32'(len) >= CommunitySize) begin
              fail = 1'b1; ec = ERR_COMM;
            end else if (eend > 17'(mend_q)) begin fail = 1'b1; ec = ERR_TRUNC; end
            else if (len == '0) begin fail = 1'b1; ec = ERR_COMM; end
            else stage_d = ST_BODY;
          end
          PH_PDU: begin
            if (eend != 17'(mend_q)) begin fail = 1'b1; ec = ERR_PDULEN; end
            else begin
              grp.cnt = 2'd1; grp.r[0] = mk(KIND_PDU, {24'd0, tag_q}, '0, '0, ERR_NONE);
              phase_d = PH_REQID; stage_d = ST_TAG;
            end
          end
          PH_REQID, PH_NONREP, PH_MAXREP: begin
            if (tag_q != 8'h02 || len == '0) begin fail = 1'b1; ec = ERR_INT; end
            else if (eend > 17'(mend_q)) begin fail = 1'b1; ec = ERR_TRUNC; end
            else begin acc_d = '0; first_d = 1'b1; stage_d = ST_BODY; end
          end
          PH_VBLIST: begin
            if (tag_q != 8'h30 || eend != 17'(mend_q)) begin fail = 1'b1; ec = ERR_VBLIST; end
            else begin phase_d = PH_VARBIND; stage_d = ST_TAG; end
          end
          PH_VARBIND: begin
            if (tag_q != 8'h30 || len == '0) begin fail = 1'b1; ec = ERR_VARBIND; end
            else begin phase_d = PH_OID; stage_d = ST_TAG; end
          end
          PH_OID: begin
            if (tag_q != 8'h06 || len == '0) begin fail = 1'b1; ec = ERR_VARBIND; end
            else if (eend > 17'(mend_q)) begin fail = 1'b1; ec = ERR_TRUNC; end
            else begin
              sidc_d = '0; sid_full_d = 1'b0; sopen_d = 1'b0; stage_d = ST_BODY;
            end
          end
          default: begin
            if ((tag_q == 8'h05) != (len == '0)) begin fail = 1'b1; ec = ERR_VARBIND; end
            else if (eend > 17'(mend_q)) begin fail = 1'b1; ec = ERR_TRUNC; end
            else if (len == '0) begin
              vbc_d = vbc_q + 5'd1; phase_d = PH_VARBIND; stage_d = ST_TAG;
            end else stage_d = ST_BODY;
          end
        endcase
      end

      // end of message verdict
      if (!fail && last_byte_i) begin
        if (!known_d) begin fail = 1'b1; ec = ERR_TRUNC; end
        else if (pos_q + 16'd1 != mend_d) begin fail = 1'b1; ec = ERR_HEADER; end
        else if (phase_d == PH_VARBIND && stage_d == ST_TAG) begin
          grp.r[grp.cnt] = mk(KIND_ACCEPT, '0, '0, '0, ERR_NONE);
          grp.cnt = grp.cnt + 2'd1;
        end else begin fail = 1'b1; ec = ERR_TRUNC; end
      end
    end

    if (fail) begin
      err_d = 1'b1;
      grp.r[grp.cnt] = mk(KIND_REJECT, '0, '0, '0, ec);
      grp.cnt = grp.cnt + 2'd1;
    end

    if (last_byte_i) begin
      phase_d = PH_OUTER; stage_d = ST_TAG; pos_d = '0; mend_d = '0; rem_d = '0;
      tag_d = '0; lbl_d = '0; acc_d = '0; sidc_d = '0; vbc_d = '0; err_d = 1'b0;
      sopen_d = 1'b0; known_d = 1'b0; first_d = 1'b0; sid_full_d = 1'b0;
    end else if (!err_d) begin
      pos_d = pos_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OUTER; stage_q <= ST_TAG; pos_q <= '0; mend_q <= '0; rem_q <= '0;
      tag_q <= '0; lbl_q <= '0; acc_q <= '0; sidc_q <= '0; vbc_q <= '0; err_q <= 1'b0;
      sopen_q <= 1'b0; known_q <= 1'b0; first_q <= 1'b0; sid_full_q <= 1'b0;
    end else if (take) begin
      phase_q <= phase_d; stage_q <= stage_d; pos_q <= pos_d; mend_q <= mend_d;
      rem_q <= rem_d; tag_q <= tag_d; lbl_q <= lbl_d; acc_q <= acc_d;
      sidc_q <= sidc_d; vbc_q <= vbc_d; err_q <= err_d; sopen_q <= sopen_d;
      known_q <= known_d; first_q <= first_d; sid_full_q <= sid_full_d;
    end
  end

  res_t ores;

  snmp_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .grp_i   (grp),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (ores),
    .last_o  (run_end_o)
  );

  assign kind_o           = ores.kind;
  assign value_o          = ores.value;
  assign varbind_number_o = ores.vb;
  assign subid_number_o   = ores.sid;
  assign error_code_o     = ores.code;

  // a message end always leaves the parser back at its start
  `SRBP_ASSERT_NEXT(a_last_clears, take && last_byte_i, phase_q == PH_OUTER && !err_q && pos_q == '0, "parser not cleared after last byte")
  // the outer length is known once the parser is past the outer header
  `SRBP_ASSERT(a_known, phase_q != PH_OUTER, known_q, "inner phase without outer length")
  // reject always carries a cause
  `SRBP_ASSERT(a_rej_code, out_valid_o && kind_o == KIND_REJECT, error_code_o != ERR_NONE, "reject without cause")
endmodule

// ===== sim/snmp_request_ber_parser_checker.sv =====
// result checker for the snmp request ber parser: predicts results per request byte
// and compares them with the output channel; depends on snmp_pkg
module snmp_request_ber_parser_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  kind_i,
  input  logic [31:0] value_i,
  input  logic [4:0]  varbind_number_i,
  input  logic [4:0]  subid_number_i,
  input  logic [3:0]  error_code_i,
  input  logic        run_end_i,
  output int          pending_o,
  output int          fails_o,
  output int          accepts_o,
  output int          rejects_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import snmp_pkg::*;

  localparam bit [7:0] TAG_INT = 8'h02, TAG_OCTETS = 8'h04, TAG_NULL = 8'h05;
  localparam bit [7:0] TAG_OID = 8'h06, TAG_SEQ = 8'h30;

  typedef enum int {
    PH_OUTER, PH_VERSION, PH_COMM, PH_PDU, PH_REQID, PH_NONREP, PH_MAXREP,
    PH_VBLIST, PH_VARBIND, PH_OID, PH_VALUE
  } phase_e;
  typedef enum int { HS_TAG, HS_LEN, HS_LENX, HS_BODY } hdr_stage_e;

  typedef struct {
    kind_e     kind;
    bit [31:0] value;
    bit [4:0]  vb;
    bit [4:0]  sid;
    err_e      code;
    bit        run_end;
  } decoded_t;

  decoded_t step_q[$];
  decoded_t decoded_q[$];

  phase_e     phase;
  hdr_stage_e stage;
  bit [31:0]  pos, msg_end, remaining, acc;
  bit [7:0]   tag;
  int unsigned len_left, subids, varbinds;
  bit err_seen, subid_open, outer_known, first_body;

  function automatic void clear_msg();
    phase = PH_OUTER; stage = HS_TAG;
    pos = 0; msg_end = 0; remaining = 0; acc = 0; tag = 0;
    len_left = 0; subids = 0; varbinds = 0;
    err_seen = 0; subid_open = 0; outer_known = 0; first_body = 0;
  endfunction

  function automatic bit tag_known(bit [7:0] t);
    case (t)
      8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h30, 8'h41, 8'h42, 8'h43,
      8'h80, 8'h81, 8'h82, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA5, 8'hA6, 8'hA7:
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void put(kind_e k, bit [31:0] v, bit [4:0] vb, bit [4:0] sid,
                              err_e c);
    decoded_t d;
    d.kind = k; d.value = v; d.vb = vb; d.sid = sid; d.code = c; d.run_end = 0;
    if (step_q.size() < 3) step_q.push_back(d);
  endfunction

  function automatic void refuse(err_e c);
    err_seen = 1;
    put(KIND_REJECT, 0, 0, 0, c);
  endfunction

  function automatic void goto_elem(phase_e p);
    phase = p; stage = HS_TAG;
  endfunction

  // element header complete: check it against what this phase allows
  function automatic void header_complete();
    bit [31:0] e;
    e = pos + 1 + remaining;
    case (phase)
      PH_OUTER: begin
        if (tag != TAG_SEQ || e > 32'hFFFF) begin refuse(ERR_HEADER); return; end
        msg_end = e; outer_known = 1; goto_elem(PH_VERSION);
      end
      PH_VERSION: begin
        if (tag != TAG_INT || remaining != 1) begin refuse(ERR_VERSION); return; end
        if (e > msg_end) begin refuse(ERR_TRUNC); return; end
        stage = HS_BODY;
      end
      PH_COMM: begin
        if (tag != TAG_OCTETS || remaining >= CommunitySize) begin
          refuse(ERR_COMM); return;
        end
        if (e > msg_end) begin refuse(ERR_TRUNC); return; end
        if (remaining == 0) begin refuse(ERR_COMM); return; end
        stage = HS_BODY;
      end
      PH_PDU: begin
        if (e != msg_end) begin refuse(ERR_PDULEN); return; end
        put(KIND_PDU, tag, 0, 0, ERR_NONE); goto_elem(PH_REQID);
      end
      PH_REQID, PH_NONREP, PH_MAXREP: begin
        if (tag != TAG_INT || remaining < 1) begin refuse(ERR_INT); return; end
        if (e > msg_end) begin refuse(ERR_TRUNC); return; end
        acc = 0; first_body = 1; stage = HS_BODY;
      end
      PH_VBLIST: begin
        if (tag != TAG_SEQ || e != msg_end) begin refuse(ERR_VBLIST); return; end
        goto_elem(PH_VARBIND);
      end
      PH_VARBIND: begin
        if (tag != TAG_SEQ || remaining < 1) begin refuse(ERR_VARBIND); return; end
        goto_elem(PH_OID);
      end
      PH_OID: begin
        if (tag != TAG_OID || remaining < 1) begin refuse(ERR_VARBIND); return; end
        if (e > msg_end) begin refuse(ERR_TRUNC); return; end
        subids = 0; subid_open = 0; stage = HS_BODY;
      end
      default: begin
        if ((tag == TAG_NULL) != (remaining == 0)) begin refuse(ERR_VARBIND); return; end
        if (e > msg_end) begin refuse(ERR_TRUNC); return; end
        if (remaining == 0) begin
          varbinds++; goto_elem(PH_VARBIND);
        end else begin
          stage = HS_BODY;
        end
      end
    endcase
  endfunction

  // base-128 sub-identifiers, the first byte split by 40
  function automatic void oid_octet(bit [7:0] b);
    if (subids == 0) begin
      if (b[7]) begin refuse(ERR_OID); return; end
      put(KIND_SUBID, b / 40, varbinds[4:0], 0, ERR_NONE);
      put(KIND_SUBID, b % 40, varbinds[4:0], 1, ERR_NONE);
      subids = 2;
    end else begin
      if (!subid_open) begin
        if (subids >= MaxSubids) begin refuse(ERR_SUBMANY); return; end
        acc = 0; subid_open = 1;
      end
      acc = (acc << 7) + b[6:0];
      if (b[7]) begin
        if (remaining == 0) begin refuse(ERR_OID); return; end
      end else begin
        put(KIND_SUBID, acc, varbinds[4:0], subids[4:0], ERR_NONE);
        subids++; subid_open = 0;
      end
    end
    if (remaining == 0) goto_elem(PH_VALUE);
  endfunction

  function automatic void body_octet(bit [7:0] b);
    remaining--;
    case (phase)
      PH_VERSION: begin
        if (b > 1) begin refuse(ERR_VERSION); return; end
        put(KIND_VERSION, b, 0, 0, ERR_NONE); goto_elem(PH_COMM);
      end
      PH_COMM: begin
        put(KIND_COMM, b, 0, 0, ERR_NONE);
        if (remaining == 0) goto_elem(PH_PDU);
      end
      PH_REQID, PH_NONREP, PH_MAXREP: begin
        // only the request id is sign extended
        if (first_body && phase == PH_REQID && b[7]) acc = 32'hFFFF_FFFF;
        first_body = 0;
        acc = (acc << 8) | b;
        if (remaining == 0) begin
          put(kind_e'(KIND_REQID + (phase - PH_REQID)), acc, 0, 0, ERR_NONE);
          goto_elem(phase_e'(phase + 1));
        end
      end
      PH_OID: oid_octet(b);
      default: begin
        if (remaining == 0) begin
          varbinds++; goto_elem(PH_VARBIND);
        end
      end
    endcase
  endfunction

  function automatic void parse_octet(bit [7:0] b);
    case (stage)
      HS_TAG: begin
        if (phase == PH_VARBIND && varbinds >= MaxVarbinds) begin
          refuse(ERR_VBMANY); return;
        end
        if (!tag_known(b)) begin refuse(ERR_TAG); return; end
        tag = b; stage = HS_LEN;
      end
      HS_LEN: begin
        if (b[7]) begin
          if (b[6:0] > 2) begin refuse(ERR_LONGLEN); return; end
          remaining = 0;
          if (b[6:0] == 0) begin header_complete(); return; end
          len_left = b[6:0]; stage = HS_LENX;
        end else begin
          remaining = b; header_complete();
        end
      end
      HS_LENX: begin
        remaining = ((remaining << 8) | b) & 32'hFFFF;
        len_left = (len_left - 1) & 3;
        if (len_left == 0) header_complete();
      end
      default: body_octet(b);
    endcase
  endfunction

  function automatic void decode_request(bit [7:0] b, bit last);
    step_q.delete();
    if (err_seen) begin
      if (last) clear_msg();
      return;
    end
    if (outer_known && pos >= msg_end) begin
      refuse(ERR_HEADER);
    end else begin
      parse_octet(b);
      if (!err_seen && last) begin
        if (!outer_known) refuse(ERR_TRUNC);
        else if (pos + 1 != msg_end) refuse(ERR_HEADER);
        else if (phase == PH_VARBIND && stage == HS_TAG)
          put(KIND_ACCEPT, 0, 0, 0, ERR_NONE);
        else refuse(ERR_TRUNC);
      end
    end
    if (last) clear_msg();
    else if (!err_seen) pos = (pos + 1) & 32'hFFFF;
    if (step_q.size() > 0) step_q[step_q.size()-1].run_end = 1;
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fails_o++;
  endtask

  initial begin
    fails_o = 0; accepts_o = 0; rejects_o = 0;
    clear_msg();
  end

  assign pending_o = decoded_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t d;
    if (!rst_ni) begin
      clear_msg();
      decoded_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) decode_request(data_byte_i, last_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          report($sformatf("unexpected result kind %0d", kind_i));
        end else begin
          d = decoded_q.pop_front();
          if (d.kind == KIND_ACCEPT) accepts_o++;
          if (d.kind == KIND_REJECT) rejects_o++;
          if (kind_i != d.kind || value_i != d.value || varbind_number_i != d.vb ||
              subid_number_i != d.sid || error_code_i != d.code || run_end_i != d.run_end)
            report($sformatf("got k%0d v%h vb%0d s%0d e%0d r%0d, want k%0d v%h vb%0d s%0d e%0d r%0d",
              kind_i, value_i, varbind_number_i, subid_number_i, error_code_i, run_end_i,
              d.kind, d.value, d.vb, d.sid, d.code, d.run_end));
        end
      end
    end
  end
endmodule

// ===== sim/tb.sv =====
// testbench top for the snmp request ber parser: builds ber messages, drives the
// request channel, stalls the result channel; depends on snmp_pkg, the checker and the rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import snmp_pkg::*;

  localparam bit [7:0] TAG_INT = 8'h02, TAG_OCTETS = 8'h04, TAG_NULL = 8'h05;
  localparam bit [7:0] TAG_OID = 8'h06, TAG_SEQ = 8'h30;

  typedef bit [7:0] octets_t[$];

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 0;
  logic        last_byte_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [3:0]  kind_o;
  logic [31:0] value_o;
  logic [4:0]  varbind_number_o;
  logic [4:0]  subid_number_o;
  logic [3:0]  error_code_o;
  logic        run_end_o;

  int pending, fails, accepts, rejects;
  int sent_bytes = 0;
  int messages = 0;
  bit calm = 0;  // no sender idling while set

  always #5 clk_i = ~clk_i;

  snmp_request_ber_parser_top dut (.*);

  snmp_request_ber_parser_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .data_byte_i, .last_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i, .kind_i(kind_o), .value_i(value_o),
    .varbind_number_i(varbind_number_o), .subid_number_i(subid_number_o),
    .error_code_i(error_code_o), .run_end_i(run_end_o),
    .pending_o(pending), .fails_o(fails), .accepts_o(accepts), .rejects_o(rejects)
  );

  // result side: random stalls, one long hold-off while requests keep coming,
  // and a stretch that never stalls
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= 400 && cyc < 480) out_ready_i <= 1'b0;
      else if (cyc >= 150 && cyc < 300) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(99) >= 22);
    end
  end

  // one request byte; valid stays up across back-to-back bytes
  task automatic send_byte(bit [7:0] b, bit last);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sent_bytes++;
  endtask

  task automatic send_msg(octets_t m);
    foreach (m[i]) send_byte(m[i], i == m.size() - 1);
    messages++;
  endtask

  function automatic octets_t rand_bytes(int n);
    octets_t q;
    repeat (n) q.push_back(8'($urandom_range(255)));
    return q;
  endfunction

  // tag plus a length in a randomly chosen valid form
  function automatic octets_t wrap(bit [7:0] t, octets_t body);
    octets_t q;
    int n;
    n = body.size();
    q.push_back(t);
    if (n == 0 && $urandom_range(3) == 0) q.push_back(8'h80);
    else if (n < 128 && $urandom_range(2) != 0) q.push_back(8'(n));
    else if (n < 256 && $urandom_range(1) == 0) begin
      q.push_back(8'h81); q.push_back(8'(n));
    end else begin
      q.push_back(8'h82); q.push_back(8'(n >> 8)); q.push_back(8'(n & 8'hFF));
    end
    return {q, body};
  endfunction

  function automatic octets_t rand_oid(int nsub);
    octets_t q;
    int w;
    bit [34:0] v;
    q.push_back(8'($urandom_range(127)));
    repeat (nsub) begin
      w = $urandom_range(1, 5);
      v = 35'({$urandom(), $urandom()});
      for (int k = w - 1; k >= 0; k--) q.push_back({k != 0, v[7*k +: 7]});
    end
    return wrap(TAG_OID, q);
  endfunction

  function automatic octets_t rand_value();
    octets_t e;
    case ($urandom_range(2))
      0: return wrap(TAG_NULL, e);
      1: return wrap(TAG_INT, rand_bytes($urandom_range(1, 4)));
      default: return wrap(TAG_OCTETS, rand_bytes($urandom_range(1, 6)));
    endcase
  endfunction

  // well-formed request with a random pdu tag and random content
  function automatic octets_t rand_request(int nvb, int maxsub);
    octets_t vbs, hdr, pdu, e;
    bit [7:0] pdu_tags[8] = '{8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA5, 8'hA6, 8'hA7, 8'hA0};
    repeat (nvb) vbs = {vbs, wrap(TAG_SEQ, {rand_oid($urandom_range(0, maxsub)),
                                           rand_value()})};
    pdu = {wrap(TAG_INT, rand_bytes($urandom_range(1, 5))),
           wrap(TAG_INT, rand_bytes($urandom_range(1, 2))),
           wrap(TAG_INT, rand_bytes($urandom_range(1, 2))),
           wrap(TAG_SEQ, vbs)};
    e.push_back(8'($urandom_range(1)));
    hdr = {wrap(TAG_INT, e), wrap(TAG_OCTETS, rand_bytes($urandom_range(1, 31)))};
    return wrap(TAG_SEQ, {hdr, wrap(pdu_tags[$urandom_range(7)], pdu)});
  endfunction

  initial begin
    octets_t m;
    int cut, p;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no-varbind request, outer and pdu lengths one too long, empty list as 0x80
    send_msg('{8'h30, 8'h14, 8'h02, 8'h01, 8'h00, 8'h04, 8'h01, 8'hFF,
               8'hA0, 8'h0C, 8'h02, 8'h01, 8'h80, 8'h02, 8'h01, 8'h7F,
               8'h02, 8'h01, 8'h00, 8'h30, 8'h80});
    send_msg('{8'h07});                             // unsupported tag
    send_msg('{8'h30, 8'h83});                      // length form too long
    send_msg('{8'h30});                             // ends before outer header
    send_msg('{8'h02, 8'h00});                      // outer not a sequence
    send_msg('{8'h30, 8'h03, 8'h02, 8'h01, 8'h02}); // bad version
    send_msg('{8'h30, 8'h04, 8'h02, 8'h01, 8'h01, 8'h04}); // ends mid-element

    // random: mostly well-formed requests, some corrupted, some noise
    while (sent_bytes < 450) begin
      calm = (sent_bytes >= 250 && sent_bytes < 320);
      case ($urandom_range(19))
        0: m = rand_bytes($urandom_range(1, 6));
        // varbind limit, kept early so the run stays near its byte budget
        1: m = rand_request((sent_bytes < 200) ? $urandom_range(20, 21) : 2, 2);
        2: m = rand_request(1, $urandom_range(18, 22));      // sub-id limit
        default: m = rand_request($urandom_range(0, 3), 5);
      endcase
      p = $urandom_range(9);
      if (p < 2) begin
        m[$urandom_range(m.size() - 1)] = 8'($urandom_range(255));
      end else if (p == 2 && m.size() > 1) begin
        cut = $urandom_range(1, m.size() - 1);
        m = m[0:cut-1];
      end else if (p == 3) begin
        m.push_back(8'($urandom_range(255)));
      end
      send_msg(m);
      // sender pause until all results are back
      if (messages == 9) begin
        in_valid_i <= 1'b0;
        wait (pending == 0);
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);

    $display("sent %0d request bytes in %0d messages", sent_bytes, messages);
    $display("results included %0d accepted and %0d rejected messages", accepts, rejects);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/snmp_pkg.sv
hdl/snmp_out_queue.sv
hdl/snmp_request_ber_parser_top.sv
sim/snmp_request_ber_parser_checker.sv
sim/tb.sv
